@@ rtl/path_token_filter_fnv1a_hash_macros.svh @@
// assertion macros for the path token filter
`ifndef PATH_TOKEN_FILTER_FNV1A_HASH_MACROS_SVH
`define PATH_TOKEN_FILTER_FNV1A_HASH_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define PTF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked out of reset
`define PTF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PTF_ASSERT_IMP(lbl, ante, cons, msg)
`define PTF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/ptf_fnv_pkg.sv @@
package ptf_fnv_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // token length saturates here, meaning longer than four bytes
    localparam logic [2:0] LEN_OVER = 3'd5;
    localparam logic [2:0] LEN_FULL = 3'd4;

    localparam int RSV_COUNT = 8;

    // first byte of a token sits in element 0
    typedef logic [3:0][7:0] t_tok_chars;

    // reserved words, zero padded: hd hi hig med low slow mob hls
    localparam t_tok_chars RSV_WORDS [RSV_COUNT] = '{
        '{8'h00, 8'h00, 8'h64, 8'h68},
        '{8'h00, 8'h00, 8'h69, 8'h68},
        '{8'h00, 8'h67, 8'h69, 8'h68},
        '{8'h00, 8'h64, 8'h65, 8'h6D},
        '{8'h00, 8'h77, 8'h6F, 8'h6C},
        '{8'h77, 8'h6F, 8'h6C, 8'h73},
        '{8'h00, 8'h62, 8'h6F, 8'h6D},
        '{8'h00, 8'h73, 8'h6C, 8'h68}
    };

    localparam logic [2:0] RSV_LENS [RSV_COUNT] = '{
        3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3
    };

    // bytes past the token length are always zero, so a full compare plus
    // a length match is an exact word match
    function automatic logic is_reserved(input t_tok_chars chars, input logic [2:0] len);
        logic hit;
        hit = 1'b0;
        for (int w = 0; w < RSV_COUNT; w++) begin
            if (len == RSV_LENS[w] && chars == RSV_WORDS[w]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // value below 72 reduced mod 9 by three conditional subtracts
    function automatic logic [3:0] mod9_small(input logic [6:0] v);
        logic [6:0] t;
        t = v;
        if (t >= 7'd36) begin
            t = t - 7'd36;
        end
        if (t >= 7'd18) begin
            t = t - 7'd18;
        end
        if (t >= 7'd9) begin
            t = t - 7'd9;
        end
        return t[3:0];
    endfunction

endpackage

@@ rtl/path_token_filter_fnv1a_hash.sv @@
// path token filter with fnv-1a hash
//
// input channel: i_valid / o_stall carry one byte of a file name per
// transaction (i_name_byte), with i_is_last on the final byte. a slash or
// backslash drops everything before it, the remaining segment is split at
// '-' and '_', reserved tokens are removed and the rest is hashed with
// 32-bit fnv-1a over sign-extended bytes.
// output channel: o_valid / i_stall carry one transaction per name, issued
// for the last byte only: o_name_hash and o_phase_slot (hash mod 18).
// throughput: one byte per cycle while o_stall is low; the hash state loop
// (xor plus multiply by the constant prime) is combinational logic between
// the state registers. the result passes the final-hash register, the mod-18
// fold register and the output register.
// reset clears the hash state to the offset basis and empties the
// pipeline. a stall on the output holds the result; the three result
// stages keep absorbing names until all are full, then o_stall rises.
// a name is finished by its last byte, the next byte starts a fresh name.
`include "path_token_filter_fnv1a_hash_macros.svh"

module path_token_filter_fnv1a_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_name_byte,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_name_hash,
    output logic [4:0]  o_phase_slot
);

    // token and hash state
    logic [31:0]             r_comm_hash;
    logic [31:0]             r_spec_hash;
    ptf_fnv_pkg::t_tok_chars r_tok_chars;
    logic [2:0]              r_tok_len;
    logic                    r_at_start;

    // result pipeline
    logic        r_a_valid;
    logic [31:0] r_a_hash;
    logic        r_b_valid;
    logic [31:0] r_b_hash;
    logic [6:0]  r_b_fold;
    logic        r_out_valid;
    logic [31:0] r_out_hash;
    logic [4:0]  r_out_slot;

    logic w_out_ready;
    logic w_b_ready;
    logic w_a_ready;
    logic w_accept;

    // per-byte next state
    logic                    w_is_sep;
    logic                    w_is_delim;
    logic                    w_append;
    logic [31:0]             w_ext;
    logic [31:0]             w_spec_app;
    ptf_fnv_pkg::t_tok_chars w_chars_app;
    logic [2:0]              w_len_app;

    logic [31:0]             n_comm_hash;
    logic [31:0]             n_spec_hash;
    ptf_fnv_pkg::t_tok_chars n_tok_chars;
    logic [2:0]              n_tok_len;
    logic                    n_at_start;
    logic [31:0]             n_final_hash;

    // mod-18 fold
    logic [30:0] w_half;
    logic [8:0]  w_sum6;
    logic [6:0]  w_fold;
    logic [3:0]  w_mod9;

    // handshake: each stage moves when it is empty or its successor moves
    assign w_out_ready = !r_out_valid || !i_stall;
    assign w_b_ready   = !r_b_valid || w_out_ready;
    assign w_a_ready   = !r_a_valid || w_b_ready;
    assign o_stall     = !w_a_ready;
    assign w_accept    = i_valid && w_a_ready;

    // byte classification
    assign w_is_sep   = (i_name_byte == ptf_fnv_pkg::CH_SLASH)
                     || (i_name_byte == ptf_fnv_pkg::CH_BSLASH);
    assign w_is_delim = (i_name_byte == ptf_fnv_pkg::CH_DASH)
                     || (i_name_byte == ptf_fnv_pkg::CH_UNDER);
    // a delimiter that opens the segment is plain data
    assign w_append   = !w_is_sep && (r_at_start || !w_is_delim);

    // hash step over the sign-extended byte
    assign w_ext      = {{24{i_name_byte[7]}}, i_name_byte};
    assign w_spec_app = (r_spec_hash ^ w_ext) * ptf_fnv_pkg::FNV_PRIME;

    // only the first four bytes of a token are kept for the reserved compare
    always_comb begin
        w_chars_app = r_tok_chars;
        if (r_tok_len < ptf_fnv_pkg::LEN_FULL) begin
            w_chars_app[r_tok_len[1:0]] = i_name_byte;
        end
        w_len_app = (r_tok_len < ptf_fnv_pkg::LEN_OVER) ? r_tok_len + 3'd1 : r_tok_len;
    end

    always_comb begin
        n_comm_hash  = r_comm_hash;
        n_spec_hash  = r_spec_hash;
        n_tok_chars  = r_tok_chars;
        n_tok_len    = r_tok_len;
        n_at_start   = r_at_start;
        n_final_hash = ptf_fnv_pkg::FNV_BASIS;

        if (w_is_sep) begin
            n_comm_hash = ptf_fnv_pkg::FNV_BASIS;
            n_spec_hash = ptf_fnv_pkg::FNV_BASIS;
            n_tok_chars = '0;
            n_tok_len   = '0;
            n_at_start  = 1'b1;
        end else if (w_append) begin
            n_spec_hash = w_spec_app;
            n_tok_chars = w_chars_app;
            n_tok_len   = w_len_app;
            n_at_start  = 1'b0;
        end else begin
            // token end: keep it unless empty or reserved
            if (r_tok_len != 3'd0 && !ptf_fnv_pkg::is_reserved(r_tok_chars, r_tok_len)) begin
                n_comm_hash = r_spec_hash;
            end else begin
                n_spec_hash = r_comm_hash;
            end
            n_tok_chars = '0;
            n_tok_len   = '0;
        end

        // the last byte closes the open token as well
        if (n_tok_len != 3'd0 && !ptf_fnv_pkg::is_reserved(n_tok_chars, n_tok_len)) begin
            n_final_hash = n_spec_hash;
        end else begin
            n_final_hash = n_comm_hash;
        end
    end

    // state update; a finished name returns to the reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comm_hash <= ptf_fnv_pkg::FNV_BASIS;
            r_spec_hash <= ptf_fnv_pkg::FNV_BASIS;
            r_tok_chars <= '0;
            r_tok_len   <= '0;
            r_at_start  <= 1'b1;
        end else if (w_accept) begin
            if (i_is_last) begin
                r_comm_hash <= ptf_fnv_pkg::FNV_BASIS;
                r_spec_hash <= ptf_fnv_pkg::FNV_BASIS;
                r_tok_chars <= '0;
                r_tok_len   <= '0;
                r_at_start  <= 1'b1;
            end else begin
                r_comm_hash <= n_comm_hash;
                r_spec_hash <= n_spec_hash;
                r_tok_chars <= n_tok_chars;
                r_tok_len   <= n_tok_len;
                r_at_start  <= n_at_start;
            end
        end
    end

    // hash mod 18 = 2 * ((hash >> 1) mod 9) + hash[0]; 64 is 1 mod 9, so
    // summing 6-bit digits keeps the residue
    assign w_half = r_a_hash[31:1];
    assign w_sum6 = 9'(w_half[5:0]) + 9'(w_half[11:6]) + 9'(w_half[17:12])
                  + 9'(w_half[23:18]) + 9'(w_half[29:24]) + 9'(w_half[30]);
    assign w_fold = 7'(w_sum6[5:0]) + 7'(w_sum6[8:6]);
    assign w_mod9 = ptf_fnv_pkg::mod9_small(r_b_fold);

    // valid bits of the result stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_a_ready) begin
                r_a_valid <= w_accept && i_is_last;
            end
            if (w_b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (w_out_ready) begin
                r_out_valid <= r_b_valid;
            end
        end
    end

    // payloads, held while their stage waits
    always_ff @(posedge i_clk) begin
        if (w_a_ready) begin
            r_a_hash <= n_final_hash;
        end
        if (w_b_ready) begin
            r_b_hash <= r_a_hash;
            r_b_fold <= w_fold;
        end
        if (w_out_ready) begin
            r_out_hash <= r_b_hash;
            r_out_slot <= {w_mod9, r_b_hash[0]};
        end
    end

    assign o_valid      = r_out_valid;
    assign o_name_hash  = r_out_hash;
    assign o_phase_slot = r_out_slot;

    // checks
    `PTF_ASSERT_IMP(a_slot_range, o_valid, o_phase_slot <= 5'd17, "phase slot out of range")
    `PTF_ASSERT_IMP(a_empty_tok_sync, r_tok_len == 3'd0,
        r_spec_hash == r_comm_hash, "hash state split with no open token")
    `PTF_ASSERT_NXT(a_name_restart, w_accept && i_is_last,
        r_at_start && r_tok_len == 3'd0 && r_comm_hash == ptf_fnv_pkg::FNV_BASIS,
        "state not cleared after last byte")

endmodule

@@ verif/path_token_filter_fnv1a_hash_test.sv @@
module path_token_filter_fnv1a_hash_test;

    // result passes the final-hash, fold and output registers once the last byte is accepted
    localparam int LATENCY     = 2;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN
    } t_stall_mode;

    // one output transaction: hash of the kept tokens and its phase slot
    typedef struct packed {
        logic [31:0] hash;
        logic [4:0]  slot;
    } t_name_result;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_name_byte = 8'h00;
    logic        i_is_last   = 1'b0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_name_hash;
    logic [4:0]  o_phase_slot;

    path_token_filter_fnv1a_hash u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_name_byte  (i_name_byte),
        .i_is_last    (i_is_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_name_hash  (o_name_hash),
        .o_phase_slot (o_phase_slot)
    );

    // ------------------------------------------------------------------
    // expected hash of each name, oldest first
    // ------------------------------------------------------------------
    t_name_result pending_hashes[$];
    int           error_count = 0;
    int           cycle_count = 0;

    // sender pacing
    bit           sender_bursty = 1'b0;
    int           burst_left    = 0;

    // receiver pacing; hold_request hands a long hold-off to the receiver
    t_stall_mode  stall_mode   = STALL_NONE;
    int           hold_request = 0;
    int           hold_left    = 0;
    int           pattern_pos  = 0;

    // bytes of the name being assembled
    logic [7:0]   name_buf[$];

    string reserved_list[8] = '{"hd", "hi", "hig", "med", "low", "slow", "mob", "hls"};
    // almost reserved: wrong length, wrong case or one byte off
    string near_list[8]     = '{"h", "hdx", "slo", "slows", "HD", "hii", "mo", "lows"};
    string hot_letters      = "hdiglowsmeb";

    // ------------------------------------------------------------------
    // hash predictor: kept-token hash plus the running hash of the token
    // under way, first four token bytes packed msb first
    // ------------------------------------------------------------------
    logic [31:0] kept_hash;
    logic [31:0] token_hash;
    logic [31:0] token_word;
    logic [2:0]  token_len;
    bit          segment_fresh;

    function automatic void restart_name();
        kept_hash     = ptf_fnv_pkg::FNV_BASIS;
        token_hash    = ptf_fnv_pkg::FNV_BASIS;
        token_word    = '0;
        token_len     = '0;
        segment_fresh = 1'b1;
    endfunction

    // bytes past the length stay zero, so length plus word is exact
    function automatic bit token_reserved();
        case ({token_len, token_word})
            {3'd2, "hd", 16'h0000}, {3'd2, "hi", 16'h0000},
            {3'd3, "hig", 8'h00},   {3'd3, "med", 8'h00},
            {3'd3, "low", 8'h00},   {3'd4, "slow"},
            {3'd3, "mob", 8'h00},   {3'd3, "hls", 8'h00}: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void hash_byte(input logic [7:0] b);
        // byte is sign extended before the xor
        token_hash = (token_hash ^ {{24{b[7]}}, b}) * ptf_fnv_pkg::FNV_PRIME;
        if (token_len < ptf_fnv_pkg::LEN_FULL) begin
            token_word[8 * (3 - token_len) +: 8] = b;
        end
        if (token_len < ptf_fnv_pkg::LEN_OVER) begin
            token_len = token_len + 3'd1;
        end
    endfunction

    function automatic void close_token();
        if (token_len != 0 && !token_reserved()) begin
            kept_hash = token_hash;
        end else begin
            token_hash = kept_hash;
        end
        token_len  = '0;
        token_word = '0;
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic last);
        t_name_result res;
        if (b == ptf_fnv_pkg::CH_SLASH || b == ptf_fnv_pkg::CH_BSLASH) begin
            restart_name();
        end else if (segment_fresh) begin
            // a delimiter opening the segment is plain data
            segment_fresh = 1'b0;
            hash_byte(b);
        end else if (b == ptf_fnv_pkg::CH_DASH || b == ptf_fnv_pkg::CH_UNDER) begin
            close_token();
        end else begin
            hash_byte(b);
        end
        if (last) begin
            close_token();
            res.hash = kept_hash;
            res.slot = 5'(kept_hash % 32'd18);
            pending_hashes.push_back(res);
            restart_name();
        end
    endfunction

    // ------------------------------------------------------------------
    // clock, watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // receiver: long hold-off when requested, otherwise the stall mode
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        pattern_pos = (pattern_pos + 1) % 7;
        if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            case (stall_mode)
                STALL_RANDOM:  i_stall <= ($urandom_range(0, 99) < 35);
                STALL_PATTERN: i_stall <= (pattern_pos < 3);
                default:       i_stall <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result checker: each accepted transaction against the oldest hash
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_name_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_hashes.size() == 0) begin
                $display("%0t unexpected result: expected none, actual hash %h slot %0d",
                         $time, o_name_hash, o_phase_slot);
                error_count++;
            end else begin
                want = pending_hashes.pop_front();
                if (o_name_hash !== want.hash) begin
                    $display("%0t name_hash mismatch: expected %h, actual %h",
                             $time, want.hash, o_name_hash);
                    error_count++;
                end
                if (o_phase_slot !== want.slot) begin
                    $display("%0t phase_slot mismatch: expected %0d, actual %0d",
                             $time, want.slot, o_phase_slot);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------
    // one byte transaction; entered just after a rising edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (sender_bursty && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        i_valid     <= 1'b1;
        i_name_byte <= b;
        i_is_last   <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_byte(b, last);
    endtask

    task automatic send_name();
        for (int i = 0; i < name_buf.size(); i++) begin
            send_byte(name_buf[i], i == name_buf.size() - 1);
        end
        name_buf.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            name_buf.push_back(s[i]);
        end
    endtask

    task automatic send_text(input string s);
        add_text(s);
        send_name();
    endtask

    // sender stops offering until every expected hash is back
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic add_delimiter();
        name_buf.push_back($urandom_range(0, 1) ? ptf_fnv_pkg::CH_DASH : ptf_fnv_pkg::CH_UNDER);
    endtask

    // mostly well formed names with random content, some pure noise
    task automatic build_random_name();
        int kind;
        int tokens;
        int n;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) name_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 2) == 0) begin
                add_text("dir");
                name_buf.push_back($urandom_range(0, 1) ? ptf_fnv_pkg::CH_SLASH
                                                        : ptf_fnv_pkg::CH_BSLASH);
            end
            if ($urandom_range(0, 5) == 0) begin
                add_delimiter();
            end
            tokens = $urandom_range(1, 4);
            for (int t = 0; t < tokens; t++) begin
                if (t != 0) begin
                    add_delimiter();
                    if ($urandom_range(0, 5) == 0) begin
                        add_delimiter();
                    end
                end
                case ($urandom_range(0, 5))
                    0, 1: add_text(reserved_list[$urandom_range(0, 7)]);
                    2:    add_text(near_list[$urandom_range(0, 7)]);
                    3: begin
                        n = $urandom_range(1, 6);
                        repeat (n) name_buf.push_back(
                            hot_letters[$urandom_range(0, hot_letters.len() - 1)]);
                    end
                    4: begin
                        // any byte, high half and separators included
                        n = $urandom_range(1, 5);
                        repeat (n) name_buf.push_back(8'($urandom_range(0, 255)));
                    end
                    default: begin
                        n = $urandom_range(5, 9);
                        repeat (n) name_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
                    end
                endcase
            end
            if ($urandom_range(0, 6) == 0) begin
                add_delimiter();
            end
            if ($urandom_range(0, 19) == 0) begin
                name_buf.push_back(ptf_fnv_pkg::CH_SLASH);
            end
        end
    endtask

    task automatic send_random_bytes(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            build_random_name();
            sent += name_buf.size();
            send_name();
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // one-byte names: plain letter, byte extremes, separator on the last byte
    task automatic test_single_bytes();
        send_text("a");
        name_buf.push_back(8'h00);
        send_name();
        name_buf.push_back(8'hFF);
        send_name();
        send_text("/");
        wait_results_drained();
    endtask

    // leading delimiter, delimiter runs, trailing delimiter, backslash
    task automatic test_delimiters();
        send_text("-x");
        send_text("a__b-");
        send_text("d\\hls");
        wait_results_drained();
    endtask

    // every reserved word removed, long token kept, high bytes hashed
    task automatic test_reserved_words();
        send_text("hd_hi_hig_med_low_slow_mob_hls");
        add_text("slows-");
        name_buf.push_back(8'h80);
        name_buf.push_back(8'h7F);
        send_name();
        wait_results_drained();
    endtask

    // random names with bursty sender, random then patterned receiver stalls
    task automatic test_random_names();
        sender_bursty = 1'b1;
        stall_mode    = STALL_RANDOM;
        send_random_bytes(650);
        // pause the sender until everything is back, then go on
        wait_results_drained();
        stall_mode = STALL_PATTERN;
        send_random_bytes(150);
        wait_results_drained();
    endtask

    // receiver holds off while short names keep coming, the block fills up
    task automatic test_back_pressure();
        sender_bursty = 1'b0;
        stall_mode    = STALL_NONE;
        hold_request  = 150;
        for (int i = 0; i < 30; i++) begin
            name_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
            add_text(i % 2 ? "_hd" : "-q");
            send_name();
        end
        wait_results_drained();
    endtask

    // back to back names with no idling on either side
    task automatic test_full_rate();
        sender_bursty = 1'b0;
        stall_mode    = STALL_NONE;
        send_random_bytes(200);
        wait_results_drained();
    endtask

    initial begin
        restart_name();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_bytes();
        test_delimiters();
        test_reserved_words();
        test_random_names();
        test_back_pressure();
        test_full_rate();

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ path_token_filter_fnv1a_hash.f @@
+incdir+rtl
rtl/ptf_fnv_pkg.sv
rtl/path_token_filter_fnv1a_hash.sv
verif/path_token_filter_fnv1a_hash_test.sv
